/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the modem reply scanner.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define MRS_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* hdl/mrs_pkg.sv */
// Types, codes and fixed character patterns of the modem reply scanner.
// No dependencies; imported by the scanner top level.
`timescale 1ns / 1ps

package mrs_pkg;

	typedef enum logic [1:0] {
		FUNC_BYTE    = 2'd0,
		FUNC_ARM_CMD = 2'd1,
		FUNC_ARM_SRV = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		PHASE_IDLE   = 2'd0,
		PHASE_HEADER = 2'd1,
		PHASE_BODY   = 2'd2
	} phase_t;

	typedef enum logic [0:0] {
		CFG_PATTERN = 1'b0,
		CFG_LENGTH  = 1'b1
	} cfg_reg_t;

	localparam int unsigned CFG_DATA_W   = 64;
	localparam int unsigned CMD_LEN_W    = 4;
	localparam int unsigned CAP_INDEX_W  = 10;
	localparam int unsigned HEADER_LEN   = 5;
	localparam int unsigned CLOSING_LEN  = 6;
	localparam logic [7:0]  FOLD_BIT     = 8'h20;
	localparam logic [7:0]  UPPER_FIRST  = 8'h41;
	localparam logic [7:0]  UPPER_LAST   = 8'h5a;

	// Folds A..Z to lower case.
	function automatic logic [7:0] fold_lower(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
			r = b | FOLD_BIT;
		end
		return r;
	endfunction

	// Header "+ipd," character at a position.
	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h2b;
			3'd1: c = 8'h69;
			3'd2: c = 8'h70;
			3'd3: c = 8'h64;
			3'd4: c = 8'h2c;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Closing "\n\rok\r\n" character at a position.
	function automatic logic [7:0] closing_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h0a;
			3'd1: c = 8'h0d;
			3'd2: c = 8'h6f;
			3'd3: c = 8'h6b;
			3'd4: c = 8'h0d;
			3'd5: c = 8'h0a;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Status and capture fields of one result word.
	typedef struct packed {
		logic                   command_found;
		logic                   command_searching;
		logic [1:0]             server_phase;
		logic                   server_complete;
		logic                   capture_valid;
		logic [7:0]             capture_char;
		logic [CAP_INDEX_W-1:0] capture_index;
	} scan_result_t;

endpackage

/* hdl/mrs_in_if.sv */
// Input channel of the modem reply scanner: valid/ready with one command word.
// No dependencies.
`timescale 1ns / 1ps

interface mrs_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

/* hdl/mrs_out_if.sv */
// Result channel of the modem reply scanner: valid/ready with one status word.
// No dependencies.
`timescale 1ns / 1ps

interface mrs_out_if;
	logic       valid;
	logic       ready;
	logic       command_found;
	logic       command_searching;
	logic [1:0] server_phase;
	logic       server_complete;
	logic       capture_valid;
	logic [7:0] capture_char;
	logic [9:0] capture_index;

	modport source (output valid, output command_found, output command_searching,
		output server_phase, output server_complete, output capture_valid,
		output capture_char, output capture_index, input ready);
	modport sink   (input valid, input command_found, input command_searching,
		input server_phase, input server_complete, input capture_valid,
		input capture_char, input capture_index, output ready);
endinterface

/* hdl/modem_reply_scanner_top.sv */
// Modem reply scanner top level: two restart-on-mismatch matchers over received bytes.
// Depends on mrs_pkg, mrs_in_if, mrs_out_if and assert_macros.svh.
`timescale 1ns / 1ps
// Usage
// The req channel carries one word per received serial byte or per arming
// command (func 0 byte, 1 arm the command reply search, 2 arm the server reply
// capture; func 3 leaves everything as it is). Every accepted word produces
// exactly one word on the rsp channel, holding the matcher status after that
// word and, while a server reply body is being captured, the lower-cased byte
// and its buffer index.
// The status is computed from the matcher registers and the incoming word
// in one pass and lands in the result register at the edge that accepts the
// word. One word is taken per cycle while the receiver does not stall; the
// only storage in the path is that result register.
// If the receiver stalls, the result waits in its register and req.ready
// falls, so at most one result is ever held; ready rises again in the same
// cycle that the waiting result is taken.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the reply
// pattern and its length; it should be written only while the block is idle.
// Reset clears both matchers, all flags, the capture count and the result
// valid flag, sets the pattern to zero and its length to one.

module modem_reply_scanner_top
	import mrs_pkg::*;
#(
	parameter int unsigned CAPTURE_DEPTH     = 1024,
	parameter int unsigned MAX_PATTERN_CHARS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mrs_in_if.sink                req,
	mrs_out_if.source             rsp,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	// The capture count must be able to hold the buffer depth itself.
	localparam int unsigned CNT_W = $clog2(CAPTURE_DEPTH + 1);
	localparam logic [CNT_W-1:0]     DEPTH_C   = CNT_W'(CAPTURE_DEPTH);
	localparam logic [CMD_LEN_W-1:0] MAX_LEN_C = CMD_LEN_W'(MAX_PATTERN_CHARS);

	// Configuration registers.
	logic [CFG_DATA_W-1:0] cfg_pattern_q;
	logic [CMD_LEN_W-1:0]  cfg_length_q;

	// Matcher state.
	logic [3:0]       cmd_pos_q,   cmd_pos_d;
	logic             cmd_armed_q, cmd_armed_d;
	logic             cmd_hit_q,   cmd_hit_d;
	phase_t           phase_q,     phase_d;
	logic [2:0]       srv_pos_q,   srv_pos_d;
	logic             srv_done_q,  srv_done_d;
	logic [CNT_W-1:0] cap_cnt_q,   cap_cnt_d;

	// Result register.
	logic         out_valid_q;
	scan_result_t res_q;
	scan_result_t res_d;

	logic                  accept;
	logic [7:0]            ch;
	logic [2:0]            cmd_idx;
	logic [7:0]            want;
	logic [3:0]            cmd_next;
	logic [CMD_LEN_W-1:0]  len_eff;
	logic [CNT_W+CAP_INDEX_W-1:0] cnt_ext;

	// A new word enters whenever the result register is empty or being emptied.
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign ch      = fold_lower(req.rx_byte);
	assign cmd_idx = cmd_pos_q[2:0];
	assign want    = cfg_pattern_q[{cmd_idx, 3'b000} +: 8];
	assign cmd_next = {1'b0, cmd_idx} + 4'd1;
	// Zero extension then truncation gives the index modulo the field size.
	assign cnt_ext = {{CAP_INDEX_W{1'b0}}, cap_cnt_q};

	// Pattern lengths of zero act as one, and lengths above the maximum act as it.
	always_comb begin
		if (cfg_length_q == '0) begin
			len_eff = CMD_LEN_W'(1);
		end else if (cfg_length_q > MAX_LEN_C) begin
			len_eff = MAX_LEN_C;
		end else begin
			len_eff = cfg_length_q;
		end
	end

	// Next matcher state and the result for the word at the input.
	always_comb begin
		cmd_pos_d   = cmd_pos_q;
		cmd_armed_d = cmd_armed_q;
		cmd_hit_d   = cmd_hit_q;
		phase_d     = phase_q;
		srv_pos_d   = srv_pos_q;
		srv_done_d  = srv_done_q;
		cap_cnt_d   = cap_cnt_q;
		res_d.capture_valid = 1'b0;
		res_d.capture_char  = 8'h00;
		res_d.capture_index = '0;

		case (req.func)
			FUNC_ARM_CMD: begin
				cmd_pos_d   = 4'd0;
				cmd_hit_d   = 1'b0;
				cmd_armed_d = 1'b1;
			end
			FUNC_ARM_SRV: begin
				srv_pos_d  = 3'd0;
				phase_d    = PHASE_HEADER;
				srv_done_d = 1'b0;
				cap_cnt_d  = '0;
			end
			FUNC_BYTE: begin
				if (cmd_armed_q) begin
					if (want == ch) begin
						cmd_pos_d = cmd_next;
						if (cmd_next >= len_eff) begin
							cmd_hit_d   = 1'b1;
							cmd_armed_d = 1'b0;
						end
					end else begin
						cmd_pos_d = 4'd0;
					end
				end

				case (phase_q)
					PHASE_HEADER: begin
						if (32'(srv_pos_q) < HEADER_LEN && header_char(srv_pos_q) == ch) begin
							if (32'(srv_pos_q) + 1 >= HEADER_LEN) begin
								phase_d   = PHASE_BODY;
								srv_pos_d = 3'd0;
							end else begin
								srv_pos_d = srv_pos_q + 3'd1;
							end
						end else begin
							srv_pos_d = 3'd0;
						end
					end
					PHASE_BODY: begin
						// Bytes past the buffer end are dropped, but the closing
						// pattern is still tracked; its own bytes are stored too.
						if (cap_cnt_q < DEPTH_C) begin
							res_d.capture_valid = 1'b1;
							res_d.capture_char  = ch;
							res_d.capture_index = cnt_ext[CAP_INDEX_W-1:0];
							cap_cnt_d           = cap_cnt_q + CNT_W'(1);
						end
						if (32'(srv_pos_q) < CLOSING_LEN && closing_char(srv_pos_q) == ch) begin
							if (32'(srv_pos_q) + 1 >= CLOSING_LEN) begin
								srv_done_d = 1'b1;
								phase_d    = PHASE_IDLE;
								srv_pos_d  = 3'd0;
							end else begin
								srv_pos_d = srv_pos_q + 3'd1;
							end
						end else begin
							srv_pos_d = 3'd0;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res_d.command_found     = cmd_hit_d;
		res_d.command_searching = cmd_armed_d;
		res_d.server_phase      = phase_d;
		res_d.server_complete   = srv_done_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_pattern_q <= '0;
			cfg_length_q  <= CMD_LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN: cfg_pattern_q <= cfg_data;
				CFG_LENGTH:  cfg_length_q  <= cfg_data[CMD_LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Matcher state advances only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_pos_q   <= 4'd0;
			cmd_armed_q <= 1'b0;
			cmd_hit_q   <= 1'b0;
			phase_q     <= PHASE_IDLE;
			srv_pos_q   <= 3'd0;
			srv_done_q  <= 1'b0;
			cap_cnt_q   <= '0;
		end else if (accept) begin
			cmd_pos_q   <= cmd_pos_d;
			cmd_armed_q <= cmd_armed_d;
			cmd_hit_q   <= cmd_hit_d;
			phase_q     <= phase_d;
			srv_pos_q   <= srv_pos_d;
			srv_done_q  <= srv_done_d;
			cap_cnt_q   <= cap_cnt_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid             = out_valid_q;
	assign rsp.command_found     = res_q.command_found;
	assign rsp.command_searching = res_q.command_searching;
	assign rsp.server_phase      = res_q.server_phase;
	assign rsp.server_complete   = res_q.server_complete;
	assign rsp.capture_valid     = res_q.capture_valid;
	assign rsp.capture_char      = res_q.capture_char;
	assign rsp.capture_index     = res_q.capture_index;

	// A found pattern always disarms the command matcher.
	`MRS_ASSERT(a_found_disarms, !(cmd_hit_q && cmd_armed_q), "command found while still armed")
	// The capture count never passes the buffer depth.
	`MRS_ASSERT(a_count_bound, cap_cnt_q <= DEPTH_C, "capture count beyond buffer depth")
	// Completion leaves the server matcher idle until it is armed again.
	`MRS_ASSERT_IMPL(a_done_idle, srv_done_q, phase_q == PHASE_IDLE,
		"server reply complete while matcher busy")
	// The server phase moves only when a word is accepted.
	`MRS_ASSERT(a_phase_on_accept, !accept |=> $stable(phase_q), "server phase moved without a word")
	// A stored body byte is reported only while capturing or on the closing byte.
	`MRS_ASSERT_IMPL(a_capture_phase, out_valid_q && res_q.capture_valid,
		res_q.server_phase == PHASE_BODY || res_q.server_complete,
		"capture reported outside the body phase")

endmodule
